FILE: design/w2s_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// World-to-screen projection package
// Shared constants, codes and types for the projection block.
// ----------------------------------------------------------------------------
package w2s_pkg;

   localparam int COORD_WIDTH_DEFAULT = 32;
   localparam int QW = 32;
   localparam int SIZE_W = 13;
   localparam logic [SIZE_W-1:0] WIDTH_RESET = 13'd640;
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;
   localparam int QDEPTH = 4;

   typedef enum logic [1:0] {
      OP_LOAD_MV   = 2'd0,
      OP_LOAD_PROJ = 2'd1,
      OP_PROJECT   = 2'd2,
      OP_UNUSED    = 2'd3
   } op_type;

   typedef enum logic {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [QW-1:0] px;
      logic signed [QW-1:0] py;
      logic signed [QW-1:0] pz;
   } point_type;

   typedef struct packed {
      op_type               op;
      logic [3:0]           idx;
      logic signed [QW-1:0] val;
      point_type            pt;
   } work_type;

   // Product of two Q16.16 values rounded to a Q32.16 result.
   function automatic logic signed [2*QW-17:0] qmul(input logic signed [QW-1:0] a,
                                                     input logic signed [QW-1:0] b);
      logic signed [2*QW-1:0] p;
      begin
         p = a * b + 64'sd32768;
         qmul = p[2*QW-1:16];
      end
   endfunction

endpackage
`default_nettype wire

FILE: design/w2s_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Projection front end
// Accepts words, drops unused opcodes and queues loads and points in order
// for the back end.
// ----------------------------------------------------------------------------
module w2s_front
   import w2s_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output logic                       full,
   input  wire logic [1:0]            op,
   input  wire logic [3:0]            entry_index,
   input  wire logic signed [QW-1:0]  entry_value,
   input  wire point_type             point,
   output logic                       q_valid,
   output work_type                   q_word,
   input  wire logic                  q_take
);

   work_type             q_ff [QDEPTH];
   logic [1:0]           wp_ff, rp_ff;
   logic [2:0]           cnt_ff;
   logic                 acc_w, keep_w;

   assign full = (cnt_ff == 3'(QDEPTH));
   assign acc_w = push && !full;
   assign keep_w = (op != OP_UNUSED);
   assign q_valid = (cnt_ff != 3'd0);
   assign q_word = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (acc_w && keep_w) begin
            q_ff[wp_ff] <= '{op: op_type'(op), idx: entry_index, val: entry_value,
                             pt: point};
            wp_ff <= wp_ff + 2'd1;
         end
         if (q_take && q_valid) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(acc_w && keep_w) - 3'(q_take && q_valid);
      end
   end

`ifndef SYNTH
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(QDEPTH)) else $error("queue count overflow");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      wp_ff == rp_ff + cnt_ff[1:0]) else $error("queue pointers disagree");
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      full && !q_take |=> full) else $error("full dropped without a take");
`endif

endmodule
`default_nettype wire

FILE: design/w2s_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined signed divider
// Computes n * 2^16 / d truncated toward zero, one quotient bit per stage.
// ----------------------------------------------------------------------------
module w2s_divider
   import w2s_pkg::*;
#(
   parameter int NW = 48,
   parameter int DW = 33,
   parameter int TW = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 en,
   input  wire logic signed [QW-1:0] n,
   input  wire logic signed [DW-1:0] d,
   input  wire logic [TW-1:0]        tag_i,
   output logic                      neg_o,
   output logic [NW-1:0]             q_o,
   output logic [TW-1:0]             tag_o
);

   localparam int RW = DW + 1;

   logic [NW-1:0] num_ff [NW+1];
   logic [RW-1:0] rem_ff [NW+1];
   logic [DW-1:0] den_ff [NW+1];
   logic          neg_ff [NW+1];
   logic [TW-1:0] tag_ff [NW+1];

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff[0] <= NW'(n[QW-1] ? -{{(NW-QW){n[QW-1]}}, n} : {{(NW-QW){1'b0}}, n}) << 16;
         den_ff[0] <= d[DW-1] ? DW'(-d) : DW'(d);
         rem_ff[0] <= '0;
         neg_ff[0] <= n[QW-1] ^ d[DW-1];
         for (int s = 0; s < NW; s++) begin
            logic [RW-1:0] t;
            t = {rem_ff[s][RW-2:0], num_ff[s][NW-1]};
            if (t >= {1'b0, den_ff[s]}) begin
               rem_ff[s+1] <= t - {1'b0, den_ff[s]};
               num_ff[s+1] <= {num_ff[s][NW-2:0], 1'b1};
            end else begin
               rem_ff[s+1] <= t;
               num_ff[s+1] <= {num_ff[s][NW-2:0], 1'b0};
            end
            den_ff[s+1] <= den_ff[s];
            neg_ff[s+1] <= neg_ff[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= NW; s++) tag_ff[s] <= '0;
      end else if (en) begin
         tag_ff[0] <= tag_i;
         for (int s = 0; s < NW; s++) tag_ff[s+1] <= tag_ff[s];
      end
   end

   assign q_o = num_ff[NW];
   assign neg_o = neg_ff[NW];
   assign tag_o = tag_ff[NW];

endmodule
`default_nettype wire

FILE: design/w2s_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Projection back end
// Applies matrix loads in order, transforms points, divides by w, maps to
// the viewport, and holds results in an output queue.
// ----------------------------------------------------------------------------
module w2s_back
   import w2s_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire work_type           q_word,
   output logic                    q_take,
   input  wire logic [SIZE_W-1:0]  width,
   input  wire logic [SIZE_W-1:0]  height,
   output logic                    empty,
   input  wire logic               pop,
   output logic signed [QW-1:0]    screen_x,
   output logic signed [QW-1:0]    screen_y,
   output logic signed [QW-1:0]    depth,
   output logic                    degenerate
);

   localparam int EW = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
   localparam int AW = QW + 20;
   localparam int NW = 48;
   localparam int OQ = 64;
   localparam int OW = 7;
   localparam logic signed [AW-1:0] HI = AW'((64'sd1 <<< (EW - 1)) - 1);
   localparam logic signed [AW-1:0] LO = -HI - 1;

   function automatic logic signed [QW-1:0] satq(input logic signed [AW+16:0] v);
      if (v > (AW+17)'(HI)) satq = QW'(HI);
      else if (v < (AW+17)'(LO)) satq = QW'(LO);
      else satq = QW'(v);
   endfunction

   // Output queue with credit so the pipeline never overruns it.
   logic [OW-1:0] credit_ff;
   logic          adv;
   logic          is_pt;
   logic          out_v;
   assign is_pt = (q_word.op == OP_PROJECT);
   assign adv = q_valid && (!is_pt || credit_ff != '0);
   assign q_take = adv;

   // Stored matrices.
   logic signed [QW-1:0] mv_ff [16];
   logic signed [QW-1:0] pj_ff [16];
   // Stage 1: model-view products.
   logic signed [AW-1:0] s1_p_ff [4][4];
   logic                 s1_v_ff, s1_l_ff;
   logic [3:0]           s1_idx_ff;
   logic signed [QW-1:0] s1_val_ff;
   // Stage 2: eye vector.
   logic signed [QW-1:0] eye_ff [4];
   logic                 s2_v_ff, s2_l_ff;
   logic [3:0]           s2_idx_ff;
   logic signed [QW-1:0] s2_val_ff;
   // Stage 3: projection products.
   logic signed [AW-1:0] s3_p_ff [3][4];
   logic signed [QW-1:0] s3_w_ff;
   logic                 s3_v_ff;
   // Stage 4: clip vector and w.
   logic signed [QW-1:0] clip_ff [3];
   logic signed [QW:0]   w_ff;
   logic                 s4_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            mv_ff[i] <= '0;
            pj_ff[i] <= '0;
         end
         s1_v_ff <= 1'b0;
         s1_l_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s2_l_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else begin
         if (adv && q_word.op == OP_LOAD_MV) mv_ff[q_word.idx] <= q_word.val;
         if (s2_l_ff) pj_ff[s2_idx_ff] <= s2_val_ff;
         s1_v_ff <= adv && is_pt;
         s1_l_ff <= adv && (q_word.op == OP_LOAD_PROJ);
         s2_v_ff <= s1_v_ff;
         s2_l_ff <= s1_l_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_idx_ff <= q_word.idx;
      s1_val_ff <= q_word.val;
      s2_idx_ff <= s1_idx_ff;
      s2_val_ff <= s1_val_ff;
      for (int r = 0; r < 4; r++) begin
         s1_p_ff[r][0] <= AW'(qmul(mv_ff[r], q_word.pt.px));
         s1_p_ff[r][1] <= AW'(qmul(mv_ff[4 + r], q_word.pt.py));
         s1_p_ff[r][2] <= AW'(qmul(mv_ff[8 + r], q_word.pt.pz));
         s1_p_ff[r][3] <= AW'(mv_ff[12 + r]);
      end
      for (int r = 0; r < 4; r++)
         eye_ff[r] <= satq((AW+17)'(s1_p_ff[r][0] + s1_p_ff[r][1] + s1_p_ff[r][2]
                                  + s1_p_ff[r][3]));
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 4; c++)
            s3_p_ff[r][c] <= AW'(qmul(pj_ff[c*4 + r], eye_ff[c]));
      s3_w_ff <= satq(-(AW+17)'(eye_ff[2]));
      for (int r = 0; r < 3; r++)
         clip_ff[r] <= satq((AW+17)'(s3_p_ff[r][0] + s3_p_ff[r][1] + s3_p_ff[r][2]
                                   + s3_p_ff[r][3]));
      w_ff <= (QW+1)'(s3_w_ff);
   end

   // Dividers: one per component, all in lockstep.
   logic [NW-1:0] qx, qy, qz;
   logic          nx_n, ny_n, nz_n;
   logic [1:0]    tg;
   logic [1:0]    tgy, tgz;
   w2s_divider #(.NW(NW), .DW(QW+1), .TW(2)) u_dx (
      .clock(clock), .reset(reset), .en(1'b1), .n(clip_ff[0]), .d(w_ff),
      .tag_i({s4_v_ff, w_ff == '0}), .neg_o(nx_n), .q_o(qx), .tag_o(tg));
   w2s_divider #(.NW(NW), .DW(QW+1), .TW(2)) u_dy (
      .clock(clock), .reset(reset), .en(1'b1), .n(clip_ff[1]), .d(w_ff),
      .tag_i(2'b00), .neg_o(ny_n), .q_o(qy), .tag_o(tgy));
   w2s_divider #(.NW(NW), .DW(QW+1), .TW(2)) u_dz (
      .clock(clock), .reset(reset), .en(1'b1), .n(clip_ff[2]), .d(w_ff),
      .tag_i(2'b00), .neg_o(nz_n), .q_o(qz), .tag_o(tgz));

   function automatic logic signed [QW-1:0] sgnsat(input logic neg, input logic [NW-1:0] q);
      logic signed [NW:0] v;
      begin
         v = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
         sgnsat = satq((AW+17)'(v));
      end
   endfunction

   // Map stages.
   logic signed [QW-1:0] n_ff [3];
   logic                 m1_v_ff, m1_d_ff;
   logic signed [QW+SIZE_W+1:0] mx_ff, my_ff;
   logic signed [QW+1:0]        mz_ff;
   logic                 m2_v_ff, m2_d_ff;
   logic signed [QW-1:0] rx_ff, ry_ff, rz_ff;
   logic                 r_v_ff, r_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
         r_v_ff <= 1'b0;
      end else begin
         m1_v_ff <= tg[1];
         m2_v_ff <= m1_v_ff;
         r_v_ff <= m2_v_ff;
      end
      n_ff[0] <= sgnsat(nx_n, qx);
      n_ff[1] <= sgnsat(ny_n, qy);
      n_ff[2] <= sgnsat(nz_n, qz);
      m1_d_ff <= tg[0];
      mx_ff <= ($signed({n_ff[0][QW-1], n_ff[0]}) + (QW+1)'(65536))
               * $signed({1'b0, width});
      my_ff <= ($signed({n_ff[1][QW-1], n_ff[1]}) + (QW+1)'(65536))
               * $signed({1'b0, height});
      mz_ff <= $signed({{2{n_ff[2][QW-1]}}, n_ff[2]}) + (QW+2)'(65536);
      m2_d_ff <= m1_d_ff;
      rx_ff <= m2_d_ff ? '0 : satq((AW+17)'(mx_ff >>> 1));
      ry_ff <= m2_d_ff ? '0 : satq((AW+17)'($signed({1'b0, height, 16'd0}))
                                    - (AW+17)'(my_ff >>> 1));
      rz_ff <= m2_d_ff ? '0 : satq((AW+17)'(mz_ff >>> 1));
      r_d_ff <= m2_d_ff;
   end

   // Output queue.
   logic [3*QW:0] oq_mem [OQ];
   logic [OW-2:0] owp_ff, orp_ff;
   logic [OW-1:0] ocnt_ff;
   logic [3*QW:0] head_ff;
   logic          head_v_ff;
   logic          rd;
   assign out_v = pop && !empty;
   assign empty = !head_v_ff;
   assign rd = (ocnt_ff != '0) && (!head_v_ff || out_v);

   always_ff @(posedge clock) begin
      if (r_v_ff) oq_mem[owp_ff] <= {r_d_ff, rx_ff, ry_ff, rz_ff};
      if (rd) head_ff <= oq_mem[orp_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         owp_ff <= '0;
         orp_ff <= '0;
         ocnt_ff <= '0;
         head_v_ff <= 1'b0;
         credit_ff <= OW'(OQ);
      end else begin
         if (r_v_ff) owp_ff <= owp_ff + (OW-1)'(1);
         if (rd) orp_ff <= orp_ff + (OW-1)'(1);
         ocnt_ff <= ocnt_ff + OW'(r_v_ff) - OW'(rd);
         if (rd) head_v_ff <= 1'b1;
         else if (out_v) head_v_ff <= 1'b0;
         credit_ff <= credit_ff - OW'(adv && is_pt) + OW'(out_v);
      end
   end

   assign degenerate = head_ff[3*QW];
   assign screen_x = head_ff[3*QW-1 -: QW];
   assign screen_y = head_ff[2*QW-1 -: QW];
   assign depth = head_ff[QW-1:0];

   logic unused;
   assign unused = ^{tgy, tgz};

`ifndef SYNTH
   a_credit: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= OW'(OQ)) else $error("credit above queue depth");
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      r_v_ff |-> ocnt_ff != OW'(OQ)) else $error("output queue overrun");
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      r_v_ff && r_d_ff |-> rx_ff == '0 && ry_ff == '0 && rz_ff == '0)
      else $error("degenerate result not zero");
`endif

endmodule
`default_nettype wire

FILE: design/world_to_screen_projection_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// World-to-screen projection
// Projects Q16.16 world points through stored model-view and projection
// matrices onto the viewport.
//
//   channel  direction  handshake          payload
//   req_     in         push / full        op, entry_index, entry_value, point
//   rsp_     out        empty / pop        screen_x, screen_y, depth, degenerate
//   csr_     in         valid / ready      index, data
//
// One word is accepted per cycle while full is low; a point's result word passes the
// transform stages, the radix-2 divider pipeline of 48 quotient-bit stages and the map stages.
// Loads pass through the same queue as points, so they take effect in order.
// Reset clears both matrices and restores a 640 by 480 viewport.
// The 64-entry result queue gives credits so result stalls never lose data;
// once credits run out the 4-entry front queue fills and raises full.
// ----------------------------------------------------------------------------
module world_to_screen_projection_top
   import w2s_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   output logic                      full,
   input  wire logic [1:0]           req_op,
   input  wire logic [3:0]           req_entry_index,
   input  wire logic signed [31:0]   req_entry_value,
   input  wire logic signed [31:0]   req_point_x,
   input  wire logic signed [31:0]   req_point_y,
   input  wire logic signed [31:0]   req_point_z,
   output logic                      empty,
   input  wire logic                 pop,
   output logic signed [31:0]        rsp_screen_x,
   output logic signed [31:0]        rsp_screen_y,
   output logic signed [31:0]        rsp_depth,
   output logic                      rsp_degenerate,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic                 csr_index,
   input  wire logic [SIZE_W-1:0]    csr_data
);

   logic [SIZE_W-1:0] width_ff, height_ff;
   logic              q_valid, q_take;
   work_type          q_word;
   point_type         pt;

   assign csr_ready = 1'b1;
   assign pt = '{px: req_point_x, py: req_point_y, pz: req_point_z};

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_WIDTH) width_ff <= csr_data;
         else height_ff <= csr_data;
      end
   end

   w2s_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full), .op(req_op),
      .entry_index(req_entry_index), .entry_value(req_entry_value), .point(pt),
      .q_valid(q_valid), .q_word(q_word), .q_take(q_take));

   w2s_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_word(q_word), .q_take(q_take), .width(width_ff),
      .height(height_ff), .empty(empty), .pop(pop), .screen_x(rsp_screen_x),
      .screen_y(rsp_screen_y), .depth(rsp_depth), .degenerate(rsp_degenerate));

endmodule
`default_nettype wire
